@@ rtl/battery_cell_voltage_monitor_defines.svh @@
// Assertion macros for the battery cell voltage monitor
`ifndef BATTERY_CELL_VOLTAGE_MONITOR_DEFINES_SVH
`define BATTERY_CELL_VOLTAGE_MONITOR_DEFINES_SVH

`define BCVM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcvm assertion failed");

`define BCVM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcvm assertion failed");

`endif

@@ rtl/bcvm_pkg.sv @@
// Shared constants, codes and types of the battery cell voltage monitor
package bcvm_pkg;

    localparam int SAMPLES_PER_READING = 16;
    localparam int ADC_VREF_MV         = 3300;
    localparam int ADC_FULL_SCALE      = 4096;

    localparam int SMP_W     = 12;
    localparam int REG_W     = 16;
    localparam int CNT_W     = 5;
    localparam int SMP_MAX   = (1 << SMP_W) - 1;
    localparam int SUM_W     = $clog2(SAMPLES_PER_READING * SMP_MAX + 1);
    localparam int P1_W      = $clog2(SMP_MAX * ADC_VREF_MV + 1);
    localparam int AMV_W     = $clog2((SMP_MAX * ADC_VREF_MV) / ADC_FULL_SCALE + 1);
    localparam int P2_W      = AMV_W + REG_W;
    localparam int DIV_CNT_W = $clog2(P2_W);
    localparam int THIRD_SH  = 17;
    localparam int THIRD_W   = REG_W + THIRD_SH;

    localparam logic [THIRD_SH-1:0] THIRD_RECIP = THIRD_SH'(43691);
    localparam logic [REG_W-1:0]    REG_MAX     = '1;

    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [1:0] CELLS_NONE  = 2'd0;
    localparam logic [1:0] CELLS_TWO   = 2'd2;
    localparam logic [1:0] CELLS_THREE = 2'd3;

    typedef enum logic [2:0] {
        CFG_POLL, CFG_NUM, CFG_DEN, CFG_MIN, CFG_BOUND, CFG_WARN, CFG_CRIT, CFG_CUT
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE, ST_AVG, ST_SCALE, ST_DIV, ST_DET, ST_PER, ST_FIN
    } t_state;

    typedef struct packed {
        logic accept;
        logic avg;
        logic scale;
        logic div_step;
        logic detect;
        logic per_cell;
        logic finish;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic fin_sample;
    } t_dp_sts;

endpackage

@@ rtl/bcvm_if.sv @@
// Channel interfaces: input items, result items and register writes
interface bcvm_in_if;
    import bcvm_pkg::*;
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [SMP_W-1:0] sample;
    modport source (output valid, cmd, sample, input ready);
    modport sink   (input valid, cmd, sample, output ready);
endinterface

interface bcvm_out_if;
    import bcvm_pkg::*;
    logic             valid;
    logic             ready;
    logic [REG_W-1:0] voltage_mv;
    logic [1:0]       cell_count;
    logic             low_warn;
    logic             critical_warn;
    logic             cut_flag;
    logic             want_sample;
    logic             reading_done;
    modport source (output valid, voltage_mv, cell_count, low_warn, critical_warn,
                    cut_flag, want_sample, reading_done, input ready);
    modport sink   (input valid, voltage_mv, cell_count, low_warn, critical_warn,
                    cut_flag, want_sample, reading_done, output ready);
endinterface

interface bcvm_cfg_if;
    import bcvm_pkg::*;
    logic             valid;
    logic             ready;
    t_cfg_idx         index;
    logic [REG_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/battery_cell_voltage_monitor.sv @@
// Battery cell voltage monitor top level: controller, datapath and checks
// Input: a tick or a non-final sample is accepted while the output register is free,
// its result registered in the cycle after. The sample that completes a reading
// blocks input through average, scale, 28-step divide, detect, per-cell and finish.
// Reset (synchronous, active low): registers to defaults, a reading is primed,
// cell count unknown, flags clear, no result pending.
`include "battery_cell_voltage_monitor_defines.svh"

module battery_cell_voltage_monitor (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bcvm_in_if.sink           i_in,
    bcvm_out_if.source        o_out,
    bcvm_cfg_if.sink          i_cfg
);
    import bcvm_pkg::*;

    t_dp_cmd ctl;
    t_dp_sts sts;

    assign i_cfg.ready = 1'b1;

    bcvm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_ctl       (ctl),
        .i_sts       (sts)
    );

    bcvm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .i_cmd           (i_in.cmd),
        .i_sample        (i_in.sample),
        .i_cfg_we        (i_cfg.valid && i_cfg.ready),
        .i_cfg_idx       (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .o_voltage_mv    (o_out.voltage_mv),
        .o_cell_count    (o_out.cell_count),
        .o_low_warn      (o_out.low_warn),
        .o_critical_warn (o_out.critical_warn),
        .o_cut_flag      (o_out.cut_flag),
        .o_want_sample   (o_out.want_sample),
        .o_reading_done  (o_out.reading_done)
    );

    `BCVM_ASSERT_IMP(a_done_stops_collect, i_clk, i_rst_n, o_out.valid && o_out.reading_done, !o_out.want_sample)
    `BCVM_ASSERT_IMP(a_no_one_cell, i_clk, i_rst_n, o_out.valid, o_out.cell_count != 2'd1)
    `BCVM_ASSERT_IMP(a_no_pack_no_flags, i_clk, i_rst_n, o_out.valid && (o_out.cell_count == CELLS_NONE), !o_out.low_warn && !o_out.critical_warn && !o_out.cut_flag)
    `BCVM_ASSERT_NXT(a_finish_blocks_input, i_clk, i_rst_n, i_in.valid && i_in.ready && sts.fin_sample, !i_in.ready)

endmodule

@@ rtl/bcvm_ctrl.sv @@
// Controller state machine: handshakes and sequencing of a reading's completion
module bcvm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output bcvm_pkg::t_dp_cmd o_ctl,
    input  bcvm_pkg::t_dp_sts i_sts
);
    import bcvm_pkg::*;

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic                 r_out_valid, n_out_valid;
    logic                 out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_div_cnt  = r_div_cnt;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = out_free;
                if (i_in_valid && out_free) begin
                    o_ctl.accept = 1'b1;
                    if (i_sts.fin_sample) begin
                        n_state = ST_AVG;
                    end else begin
                        o_ctl.out_load = 1'b1;
                    end
                end
            end
            ST_AVG: begin
                o_ctl.avg = 1'b1;
                n_state   = ST_SCALE;
            end
            ST_SCALE: begin
                o_ctl.scale = 1'b1;
                n_div_cnt   = '0;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                o_ctl.div_step = 1'b1;
                if (r_div_cnt == DIV_CNT_W'(P2_W - 1)) begin
                    n_state = ST_DET;
                end else begin
                    n_div_cnt = r_div_cnt + 1'b1;
                end
            end
            ST_DET: begin
                o_ctl.detect = 1'b1;
                n_state      = ST_PER;
            end
            ST_PER: begin
                o_ctl.per_cell = 1'b1;
                n_state        = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    o_ctl.finish   = 1'b1;
                    o_ctl.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_valid = o_ctl.out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

endmodule

@@ rtl/bcvm_dp.sv @@
// Datapath: registers, sample accumulation, scaling, bit-serial divider and flags
module bcvm_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bcvm_pkg::t_dp_cmd               i_ctl,
    output bcvm_pkg::t_dp_sts               o_sts,
    input  logic                            i_cmd,
    input  logic [bcvm_pkg::SMP_W-1:0]      i_sample,
    input  logic                            i_cfg_we,
    input  bcvm_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [bcvm_pkg::REG_W-1:0]      i_cfg_data,
    output logic [bcvm_pkg::REG_W-1:0]      o_voltage_mv,
    output logic [1:0]                      o_cell_count,
    output logic                            o_low_warn,
    output logic                            o_critical_warn,
    output logic                            o_cut_flag,
    output logic                            o_want_sample,
    output logic                            o_reading_done
);
    import bcvm_pkg::*;

    logic [REG_W-1:0] r_poll, r_num, r_den, r_min, r_bound, r_warn, r_crit, r_cut;
    logic [REG_W-1:0] r_elapsed;
    logic             r_collecting;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] r_sum;
    logic [REG_W-1:0] r_last_mv;
    logic [1:0]       r_cells;
    logic [2:0]       r_flags;
    logic [P2_W-1:0]  r_prod;
    logic [REG_W-1:0] r_rem;
    logic [REG_W-1:0] r_per;

    logic [SUM_W-1:0] n_sum;
    logic [REG_W-1:0] elapsed_inc;
    logic             start;
    logic [SMP_W-1:0] avg;
    logic [P1_W-1:0]  p1;
    logic [AMV_W-1:0] adc_mv;
    logic [P2_W-1:0]  p2;
    logic [REG_W:0]   rem_sh;
    logic             rem_ge;
    logic [REG_W-1:0] mv_sat;
    logic [1:0]       n_cells;
    logic [THIRD_W-1:0] third_prod;
    logic [2:0]       n_flags;

    always_comb begin
        n_sum       = r_sum + SUM_W'(i_sample);
        elapsed_inc = (r_elapsed != REG_MAX) ? r_elapsed + 1'b1 : r_elapsed;
        start       = !r_collecting && (elapsed_inc >= r_poll);
        o_sts.fin_sample = (i_cmd == CMD_SAMPLE) && r_collecting &&
            ((CNT_W + 1)'(r_cnt) + 1'b1 >= (CNT_W + 1)'(SAMPLES_PER_READING));
        avg    = SMP_W'(r_sum / SAMPLES_PER_READING);
        p1     = P1_W'(avg) * P1_W'(ADC_VREF_MV);
        adc_mv = AMV_W'(r_prod[P1_W-1:0] / ADC_FULL_SCALE);
        p2     = P2_W'(adc_mv) * P2_W'(r_den);
        rem_sh = {r_rem, r_prod[P2_W-1]};
        rem_ge = rem_sh >= {1'b0, r_num};
        mv_sat = (|r_prod[P2_W-1:REG_W]) ? REG_MAX : r_prod[REG_W-1:0];
        if (r_cells != CELLS_NONE) begin
            n_cells = r_cells;
        end else if (mv_sat < r_min) begin
            n_cells = CELLS_NONE;
        end else if (mv_sat >= r_bound) begin
            n_cells = CELLS_THREE;
        end else begin
            n_cells = CELLS_TWO;
        end
        third_prod = THIRD_W'(r_last_mv) * THIRD_W'(THIRD_RECIP);
        if (r_cells == CELLS_NONE) begin
            n_flags = 3'b000;
        end else begin
            n_flags = {r_per <= r_cut, r_per <= r_crit, r_per <= r_warn};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll       <= REG_W'(500);
            r_num        <= REG_W'(1);
            r_den        <= REG_W'(11);
            r_min        <= REG_W'(5000);
            r_bound      <= REG_W'(8700);
            r_warn       <= REG_W'(3500);
            r_crit       <= REG_W'(3200);
            r_cut        <= REG_W'(3000);
            r_elapsed    <= '0;
            r_collecting <= 1'b1;
            r_cnt        <= '0;
            r_sum        <= '0;
            r_last_mv    <= '0;
            r_cells      <= CELLS_NONE;
            r_flags      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_POLL:  r_poll  <= i_cfg_data;
                    CFG_NUM:   r_num   <= i_cfg_data;
                    CFG_DEN:   r_den   <= i_cfg_data;
                    CFG_MIN:   r_min   <= i_cfg_data;
                    CFG_BOUND: r_bound <= i_cfg_data;
                    CFG_WARN:  r_warn  <= i_cfg_data;
                    CFG_CRIT:  r_crit  <= i_cfg_data;
                    CFG_CUT:   r_cut   <= i_cfg_data;
                    default:   r_poll  <= r_poll;
                endcase
            end
            if (i_ctl.accept) begin
                if (i_cmd == CMD_SAMPLE) begin
                    if (r_collecting) begin
                        r_sum <= n_sum;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end else begin
                    r_elapsed <= start ? '0 : elapsed_inc;
                    if (start) begin
                        r_collecting <= 1'b1;
                        r_cnt        <= '0;
                        r_sum        <= '0;
                    end
                end
            end
            if (i_ctl.detect) begin
                r_last_mv <= mv_sat;
                r_cells   <= n_cells;
            end
            if (i_ctl.finish) begin
                r_flags      <= n_flags;
                r_collecting <= 1'b0;
                r_cnt        <= '0;
                r_sum        <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.avg) begin
            r_prod <= P2_W'(p1);
        end
        if (i_ctl.scale) begin
            r_prod <= p2;
            r_rem  <= '0;
        end
        if (i_ctl.div_step) begin
            r_rem  <= rem_ge ? REG_W'(rem_sh - {1'b0, r_num}) : REG_W'(rem_sh);
            r_prod <= {r_prod[P2_W-2:0], rem_ge};
        end
        if (i_ctl.per_cell) begin
            r_per <= (r_cells == CELLS_THREE) ? REG_W'(third_prod >> THIRD_SH)
                                               : (r_last_mv >> 1);
        end
        if (i_ctl.out_load) begin
            o_voltage_mv <= r_last_mv;
            o_cell_count <= r_cells;
            if (i_ctl.finish) begin
                {o_cut_flag, o_critical_warn, o_low_warn} <= n_flags;
                o_want_sample  <= 1'b0;
                o_reading_done <= 1'b1;
            end else begin
                {o_cut_flag, o_critical_warn, o_low_warn} <= r_flags;
                o_want_sample  <= (i_cmd == CMD_SAMPLE) ? r_collecting
                                                        : (r_collecting || start);
                o_reading_done <= 1'b0;
            end
        end
    end

endmodule
